[src/unorm_pkg.sv]
// Package for the URL path normalizer: character codes, queue sizing,
// the queue word type and the decode helper functions.
// No dependencies; imported by every module of the block.
package unorm_pkg;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [1:0] cnt;
        logic       fin;
        logic       safe;
    } unorm_entry_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] prev;
        logic       cut;
        logic       unsafe_seen;
    } unorm_dec_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] r;
        r = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = 4'(c[3:0] + 4'd9);
        end
        return r;
    endfunction

    function automatic logic [7:0] plain_map(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    function automatic unorm_dec_t push_decoded(input logic [7:0] c_in, input unorm_dec_t st);
        unorm_dec_t r;
        logic [7:0] c;
        r = st;
        r.emit = 1'b0;
        c = (c_in == CH_BSLASH) ? CH_SLASH : c_in;
        if (!st.cut) begin
            if (c == CH_QUEST) begin
                r.cut = 1'b1;
            end else if (!(c == CH_SLASH && st.prev == CH_SLASH)) begin
                if (c == CH_NUL || (st.prev == CH_DOT && (c == CH_DOT || c == CH_SLASH))
                        || (st.prev == CH_SLASH && c == CH_DOT)) begin
                    r.unsafe_seen = 1'b1;
                end
                r.prev = c;
                r.emit = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

[src/unorm_front.sv]
// Front end of the URL path normalizer: accepts raw bytes, decodes escapes,
// tracks cut, slash and safety state and writes a queue word for each byte
// that emits output or ends a path. Depends on unorm_pkg.
module unorm_front import unorm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [7:0]   s_in_byte,
    input  logic         s_is_final,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         q_full,
    output logic         q_push,
    output unorm_entry_t q_entry
);

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    logic [1:0] stage_reg, stage_next;
    logic [3:0] held_reg, held_next;
    logic [7:0] prev_reg;
    logic       cut_reg, unsafe_reg;

    logic       a0, a1;
    logic [7:0] c0, c1;
    logic [7:0] v;
    unorm_dec_t st0, st1, st2;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign v       = {held_reg, hex_value(s_in_byte)};

    always_comb begin
        a0         = 1'b0;
        a1         = 1'b0;
        c0         = s_in_byte;
        c1         = plain_map(s_in_byte);
        stage_next = ESC_NONE;
        held_next  = held_reg;
        unique case (stage_reg)
            ESC_PCT: begin
                if (s_is_final) begin
                    a0 = 1'b1;
                    c0 = CH_PERCENT;
                    a1 = 1'b1;
                end else begin
                    held_next  = hex_value(s_in_byte);
                    stage_next = ESC_DIGIT;
                end
            end
            ESC_DIGIT: begin
                a0 = (v != 8'd0);
                c0 = v;
            end
            default: begin
                if (s_in_byte == CH_PERCENT) begin
                    if (s_is_final) begin
                        a0 = 1'b1;
                        c0 = CH_PERCENT;
                    end else begin
                        stage_next = ESC_PCT;
                    end
                end else begin
                    a0 = 1'b1;
                    c0 = plain_map(s_in_byte);
                end
            end
        endcase
    end

    always_comb begin
        st0 = '{emit: 1'b0, prev: prev_reg, cut: cut_reg, unsafe_seen: unsafe_reg};
        st1 = a0 ? push_decoded(c0, st0) : st0;
        st1.emit = a0 && st1.emit;
        st2 = a1 ? push_decoded(c1, st1) : st1;
        st2.emit = a1 && st2.emit;
    end

    always_comb begin
        q_entry.byte0 = st1.emit ? st1.prev : st2.prev;
        q_entry.byte1 = st2.prev;
        q_entry.cnt   = {st1.emit && st2.emit, st1.emit ^ st2.emit};
        q_entry.fin   = s_is_final;
        q_entry.safe  = !st2.unsafe_seen;
        q_push        = accept && (st1.emit || st2.emit || s_is_final);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg  <= ESC_NONE;
            held_reg   <= 4'd0;
            prev_reg   <= CH_NUL;
            cut_reg    <= 1'b0;
            unsafe_reg <= 1'b0;
        end else if (accept) begin
            if (s_is_final) begin
                stage_reg  <= ESC_NONE;
                held_reg   <= 4'd0;
                prev_reg   <= CH_NUL;
                cut_reg    <= 1'b0;
                unsafe_reg <= 1'b0;
            end else begin
                stage_reg  <= stage_next;
                held_reg   <= held_next;
                prev_reg   <= st2.prev;
                cut_reg    <= st2.cut;
                unsafe_reg <= st2.unsafe_seen;
            end
        end
    end

endmodule

[src/unorm_queue.sv]
// Short queue between the front and back ends of the URL path normalizer.
// Holds decoded words in flip-flops; depends on unorm_pkg.
module unorm_queue import unorm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  unorm_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         q_valid,
    output unorm_entry_t q_entry
);

    unorm_entry_t     mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]   count_reg, count_next;

    assign full    = (count_reg == QCW'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= QAW'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= QAW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("queue read while empty");
`endif

endmodule

[src/unorm_back.sv]
// Back end of the URL path normalizer: turns each queue word into one or two
// result words in an output register with a one-word pending slot.
// Depends on unorm_pkg.
module unorm_back import unorm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    input  unorm_entry_t q_entry,
    output logic         q_pop,
    output logic [7:0]   m_out_byte,
    output logic         m_byte_valid,
    output logic         m_end_of_path,
    output logic         m_path_safe,
    output logic         m_valid,
    input  logic         m_ready
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bv_reg, out_end_reg, out_safe_reg;
    logic       pend_valid_reg;
    logic [7:0] pend_byte_reg;
    logic       pend_end_reg, pend_safe_reg;
    logic       out_free, two, last_first;

    assign out_free   = !out_valid_reg || m_ready;
    assign q_pop      = out_free && !pend_valid_reg && q_valid;
    assign two        = (q_entry.cnt == 2'd2);
    assign last_first = q_entry.fin && !two;

    assign m_valid       = out_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_byte_valid  = out_bv_reg;
    assign m_end_of_path = out_end_reg;
    assign m_path_safe   = out_safe_reg;

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (pend_valid_reg) begin
                out_byte_reg <= pend_byte_reg;
                out_bv_reg   <= 1'b1;
                out_end_reg  <= pend_end_reg;
                out_safe_reg <= pend_safe_reg;
            end else if (q_valid) begin
                out_byte_reg <= (q_entry.cnt == 2'd0) ? 8'd0 : q_entry.byte0;
                out_bv_reg   <= (q_entry.cnt != 2'd0);
                out_end_reg  <= last_first;
                out_safe_reg <= last_first && q_entry.safe;
            end
        end
        if (q_pop) begin
            pend_byte_reg <= q_entry.byte1;
            pend_end_reg  <= q_entry.fin;
            pend_safe_reg <= q_entry.fin && q_entry.safe;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= pend_valid_reg || q_valid;
            pend_valid_reg <= q_pop && two;
        end
    end

`ifndef SYNTHESIS
    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg)
        else $error("second word pending with empty output register");
    a_safe_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_safe_reg) |-> out_end_reg)
        else $error("safe flag set on a word that does not end the path");
    a_empty_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_bv_reg) |-> out_end_reg)
        else $error("word without a byte that does not end the path");
`endif

endmodule

[src/url_path_normalizer_top.sv]
// Top level of the URL path normalizer: front end, queue and back end.
// Depends on unorm_pkg, unorm_front, unorm_queue and unorm_back.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   s_in_byte, s_is_final
//   m_       out        m_valid / m_ready   m_out_byte, m_byte_valid,
//                                           m_end_of_path, m_path_safe
//
// One raw byte is accepted per cycle while the queue is not full; each result word
// passes the queue and the output register. A final byte after a lone percent sign
// makes two words, the second held in the pending slot; the four-word queue absorbs it.
// Reset is synchronous and active low and clears all path state and the queue.
// s_ready drops only while the queue is full, so an output stall reaches the input
// after the output register, the pending slot and the queue fill.
module url_path_normalizer_top import unorm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_in_byte,
    input  logic       s_is_final,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_end_of_path,
    output logic       m_path_safe,
    output logic       m_valid,
    input  logic       m_ready
);

    logic         q_full, q_push, q_pop, q_valid;
    unorm_entry_t push_entry, pop_entry;

    unorm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_in_byte  (s_in_byte),
        .s_is_final (s_is_final),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    unorm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_entry    (pop_entry)
    );

    unorm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_entry       (pop_entry),
        .q_pop         (q_pop),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_end_of_path (m_end_of_path),
        .m_path_safe   (m_path_safe),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule
